// ----- rtl/sprite_chain_expander_assert.svh -----
// ----------------------------------------------------------------------------
// Sprite chain expander assertion macros
// Property macros used by the expander's top-level module to check its logic.
// ----------------------------------------------------------------------------
`ifndef SPRITE_CHAIN_EXPANDER_ASSERT_SVH
`define SPRITE_CHAIN_EXPANDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sce_pkg.sv -----
// ----------------------------------------------------------------------------
// Sprite chain expander package
// Types, constants and field positions shared by the expander's modules.
// ----------------------------------------------------------------------------
package sce_pkg;

    localparam int IN_W   = 64;
    localparam int OUT_W  = 64;
    localparam int CFG_W  = 16;
    localparam int POS_W  = 17;
    localparam int CODE_W = 15;

    // Control byte bit positions, counted inside the whole input word.
    localparam int CTRL_LSB          = 32;
    localparam int CTRL_INACTIVE_BIT = CTRL_LSB + 7;

    localparam logic [CFG_W-1:0] PRIO_SEL_BITS = 16'h8800;
    localparam logic [7:0]       MASK_HIGH     = 8'hf0;
    localparam logic [7:0]       MASK_LOW      = 8'hfc;
    localparam logic [POS_W-1:0] STEP_FWD      = 17'h00010;
    localparam logic [POS_W-1:0] STEP_BACK     = 17'h1fff0;

    typedef enum logic
    {
        SCE_IDLE,
        SCE_RUN
    } sce_state_t;

    typedef struct packed
    {
        logic load;
        logic emit;
    } sce_cmd_t;

    typedef struct packed
    {
        logic out_free;
        logic last_item;
    } sce_status_t;

endpackage

// ----- rtl/sce_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sprite chain expander controller
// Accepts list entries and sequences the emission of their tile placements.
// ----------------------------------------------------------------------------
module sce_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_inactive,
    input  sce_pkg::sce_status_t status,
    output logic                in_ready,
    output sce_pkg::sce_cmd_t   cmd,
    output logic                busy
);
    import sce_pkg::*;

    sce_state_t state_reg;
    sce_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SCE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        case (state_reg)
            SCE_IDLE:
            begin
                in_ready = 1'b1;
                // Inactive entries are dropped without leaving idle.
                if (in_valid && !in_inactive)
                begin
                    cmd.load   = 1'b1;
                    state_next = SCE_RUN;
                end
            end
            SCE_RUN:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_item)
                    begin
                        state_next = SCE_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = SCE_IDLE;
            end
        endcase
    end

    assign busy = (state_reg == SCE_RUN);

endmodule

// ----- rtl/sce_datapath.sv -----
// ----------------------------------------------------------------------------
// Sprite chain expander datapath
// Holds the loaded entry, walks the chain and drives the output register.
// ----------------------------------------------------------------------------
module sce_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [sce_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic [sce_pkg::IN_W-1:0]    in_data,
    input  sce_pkg::sce_cmd_t           cmd,
    output sce_pkg::sce_status_t        status,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sce_pkg::OUT_W-1:0]   out_data,
    output logic                        out_last
);
    import sce_pkg::*;

    logic [CFG_W-1:0]  prio_reg;
    logic [POS_W-1:0]  cx_reg;
    logic [POS_W-1:0]  cy_reg;
    logic [CODE_W-1:0] code_reg;
    logic [2:0]        remain_reg;
    logic [3:0]        pal_reg;
    logic              mirror_x_reg;
    logic              mirror_y_reg;
    logic [7:0]        mask_reg;
    logic              step_y_reg;
    logic              step_neg_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [OUT_W-1:0]  out_data_reg;
    logic              out_last_reg;

    logic [7:0]        ctrl;
    logic [2:0]        chain;
    logic              ychain;
    logic              flipy;
    logic              flipx;
    logic [POS_W-1:0]  x_ext;
    logic [POS_W-1:0]  y_ext;
    logic [POS_W-1:0]  offset;
    logic [POS_W-1:0]  step_val;

    assign ctrl   = in_data[CTRL_LSB +: 8];
    assign chain  = ctrl[2:0];
    assign ychain = ctrl[3];
    assign flipy  = ctrl[4];
    assign flipx  = ctrl[5];
    assign x_ext  = {in_data[15], in_data[15:0]};
    assign y_ext  = {in_data[31], in_data[31:16]};
    assign offset = {10'd0, chain, 4'd0};
    assign step_val = step_neg_reg ? STEP_BACK : STEP_FWD;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                prio_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg       <= x_ext + ((!ychain && flipx) ? offset : '0);
            cy_reg       <= y_ext + (( ychain && flipy) ? offset : '0);
            code_reg     <= {1'b0, in_data[53:40]};
            remain_reg   <= chain;
            pal_reg      <= in_data[59:56];
            mirror_x_reg <= flipx;
            mirror_y_reg <= flipy;
            mask_reg     <= ((prio_reg & PRIO_SEL_BITS) != '0) ? MASK_HIGH : MASK_LOW;
            step_y_reg   <= ychain;
            step_neg_reg <= ychain ? flipy : flipx;
        end
        else if (cmd.emit)
        begin
            cx_reg     <= step_y_reg ? cx_reg : cx_reg + step_val;
            cy_reg     <= step_y_reg ? cy_reg + step_val : cy_reg;
            code_reg   <= code_reg + 15'd1;
            remain_reg <= remain_reg - 3'd1;
        end
        if (cmd.emit)
        begin
            out_data_reg <= {1'b0, mask_reg, mirror_y_reg, mirror_x_reg, pal_reg,
                             cy_reg, cx_reg, code_reg};
            out_last_reg <= (remain_reg == '0);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.last_item = (remain_reg == '0);
    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;
    assign out_last         = out_last_reg;

endmodule

// ----- rtl/sprite_chain_expander.sv -----
// An accepted active entry is loaded into the datapath registers; each placement then
// passes through the output register, one placement a cycle while the output is not stalled.
// An inactive entry is taken while idle and gives no word; output stalls hold the chain walk.
// The chain is walked one tile per cycle when the output is free, by a single adder pair.
// Reset (rst_n low, asynchronous) empties the output and clears the priority word to zero.
// ----------------------------------------------------------------------------
// Sprite chain expander
// Expands eight-byte sprite list entries into chains of 16-pixel tile placements.
// ----------------------------------------------------------------------------
`include "sprite_chain_expander_assert.svh"

module sprite_chain_expander
(
    input  logic                        clk,
    input  logic                        rst_n,
    // Priority word register write port.
    input  logic                        cfg_we,
    input  logic [sce_pkg::CFG_W-1:0]   cfg_wdata,
    // Sprite list entry words.
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // From bit 0 up: x_low_byte, x_high_byte, y_low_byte, y_high_byte,
    // control_byte, code_low_byte, code_high_byte, colour_byte.
    input  logic [sce_pkg::IN_W-1:0]    s_axis_tdata,
    // Tile placement words.
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // From bit 0 up: tile_code[15], pos_x[17], pos_y[17], palette[4],
    // mirror_x, mirror_y, priority_mask[8], one zero pad bit.
    output logic [sce_pkg::OUT_W-1:0]   m_axis_tdata,
    // The last_tile field: high on the final placement of an entry.
    output logic                        m_axis_tlast
);
    import sce_pkg::*;

    sce_cmd_t    cmd;
    sce_status_t status;
    logic        busy;

    // The controller only decides when to load an entry and when to emit a placement;
    // all coordinate and code arithmetic lives in the datapath.
    sce_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_inactive (s_axis_tdata[CTRL_INACTIVE_BIT]),
        .status      (status),
        .in_ready    (s_axis_tready),
        .cmd         (cmd),
        .busy        (busy)
    );

    // The datapath owns the output register, so a finished placement can wait for the
    // consumer while the controller is already back in idle taking the next entry.
    sce_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

    // While a chain is being walked no new entry may enter.
    `SCE_ASSERT_NOW(a_no_accept_busy, busy, !s_axis_tready, "entry accepted while busy")
    // An accepted active entry starts a chain walk.
    `SCE_ASSERT_NEXT(a_active_starts, s_axis_tvalid && s_axis_tready && !s_axis_tdata[CTRL_INACTIVE_BIT], busy, "active entry did not start a chain")
    // Emitting the final placement returns the controller to idle, flagged as last.
    `SCE_ASSERT_NEXT(a_last_ends, cmd.emit && status.last_item, !busy && m_axis_tvalid && m_axis_tlast, "chain did not end on last placement")
    // Loading and emitting never happen together.
    `SCE_ASSERT_NOW(a_cmd_excl, cmd.load, !cmd.emit, "load and emit in the same cycle")

endmodule

// ----- tb/sce_placement_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile placement checker
// Watches the configuration port and both stream channels of the sprite chain
// expander. It expands each accepted sprite entry into the placements it
// should give and compares every output word with the oldest one due.
// ----------------------------------------------------------------------------
module sce_placement_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [sce_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [sce_pkg::IN_W-1:0]    s_axis_tdata,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [sce_pkg::OUT_W-1:0]   m_axis_tdata,
    input  logic                        m_axis_tlast,
    output int                          mismatches,
    output int                          placements_pending,
    output int                          placements_checked
);

    typedef struct packed
    {
        logic [14:0] tile_code;
        logic [16:0] pos_x;
        logic [16:0] pos_y;
        logic [3:0]  palette;
        logic        mirror_x;
        logic        mirror_y;
        logic [7:0]  prio_mask;
        logic        last_tile;
    } placement_t;

    placement_t              placements_due[$];
    logic [sce_pkg::CFG_W-1:0] prio_shadow;

    initial
    begin
        mismatches         = 0;
        placements_pending = 0;
        placements_checked = 0;
    end

    // Our copy of the priority word follows the write port.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prio_shadow <= '0;
        else if (cfg_we)
            prio_shadow <= cfg_wdata;
    end

    // Works out the placements of one entry and queues them in order.
    task automatic expand_entry(input logic [63:0] entry);
        logic [7:0]         ctrl;
        logic signed [16:0] cx;
        logic signed [16:0] cy;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [16:0] far_end;
        logic [14:0]        base;
        int                 tiles;
        placement_t         p;
        ctrl = entry[39:32];
        if (ctrl[7])
            return;
        cx      = {entry[15], entry[15:0]};
        cy      = {entry[31], entry[31:16]};
        base    = {1'b0, entry[53:40]};
        far_end = $signed({10'd0, ctrl[2:0], 4'd0});
        dx      = '0;
        dy      = '0;
        // Only the flip of the chain's own axis moves the chain.
        if (ctrl[3])
        begin
            if (ctrl[4])
            begin
                cy = cy + far_end;
                dy = -17'sd16;
            end
            else
                dy = 17'sd16;
        end
        else
        begin
            if (ctrl[5])
            begin
                cx = cx + far_end;
                dx = -17'sd16;
            end
            else
                dx = 17'sd16;
        end
        tiles = int'(ctrl[2:0]) + 1;
        for (int k = 0; k < tiles; k++)
        begin
            p.tile_code = base + 15'(k);
            p.pos_x     = cx;
            p.pos_y     = cy;
            p.palette   = entry[59:56];
            p.mirror_x  = ctrl[5];
            p.mirror_y  = ctrl[4];
            p.prio_mask = ((prio_shadow & sce_pkg::PRIO_SEL_BITS) != '0) ?
                          sce_pkg::MASK_HIGH : sce_pkg::MASK_LOW;
            p.last_tile = (k == tiles - 1);
            placements_due.push_back(p);
            cx = cx + dx;
            cy = cy + dy;
        end
    endtask

    task automatic compare_field(input string label, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, label, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        placement_t want;
        placement_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expand_entry(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.tile_code = m_axis_tdata[14:0];
                got.pos_x     = m_axis_tdata[31:15];
                got.pos_y     = m_axis_tdata[48:32];
                got.palette   = m_axis_tdata[52:49];
                got.mirror_x  = m_axis_tdata[53];
                got.mirror_y  = m_axis_tdata[54];
                got.prio_mask = m_axis_tdata[62:55];
                got.last_tile = m_axis_tlast;
                if (placements_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: placement word expected none, got %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    want = placements_due.pop_front();
                    placements_checked++;
                    compare_field("tile_code", want.tile_code, got.tile_code);
                    compare_field("pos_x", $signed(want.pos_x), $signed(got.pos_x));
                    compare_field("pos_y", $signed(want.pos_y), $signed(got.pos_y));
                    compare_field("palette", want.palette, got.palette);
                    compare_field("mirror_x", want.mirror_x, got.mirror_x);
                    compare_field("mirror_y", want.mirror_y, got.mirror_y);
                    compare_field("priority_mask", want.prio_mask, got.prio_mask);
                    compare_field("last_tile", want.last_tile, got.last_tile);
                end
            end
            placements_pending = placements_due.size();
        end
    end

endmodule

// ----- tb/tb_sprite_chain_expander.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite chain expander testbench
// Feeds directed and random sprite entries under several priority words,
// with random idling on both stream sides, while a checker module predicts
// and compares every tile placement word.
// ----------------------------------------------------------------------------
module tb_sprite_chain_expander;

    // Cycles the receiver refuses words once, long enough to back up the input.
    localparam int HOLD_CYCLES         = 400;
    // Cycles waited once no placement is pending, enough to be sure the block is idle.
    localparam int SETTLE_CYCLES       = 4;
    localparam int DRAIN_CYCLES        = 20;
    // Longest legal quiet spell is the hold-off plus one sender gap.
    localparam int STALL_LIMIT         = 3000;
    localparam int NUM_SETTINGS        = 6;
    localparam int ENTRIES_PER_SETTING = 75;

    // Control byte flags of a sprite entry.
    localparam logic [7:0] CTRL_CHAIN_Y  = 8'h08;
    localparam logic [7:0] CTRL_FLIP_Y   = 8'h10;
    localparam logic [7:0] CTRL_FLIP_X   = 8'h20;
    localparam logic [7:0] CTRL_SPARE    = 8'h40;
    localparam logic [7:0] CTRL_INACTIVE = 8'h80;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [sce_pkg::CFG_W-1:0]   cfg_wdata;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    // From bit 0 up: x_low_byte, x_high_byte, y_low_byte, y_high_byte,
    // control_byte, code_low_byte, code_high_byte, colour_byte.
    logic [sce_pkg::IN_W-1:0]    s_axis_tdata;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    // From bit 0 up: tile_code, pos_x, pos_y, palette, mirror_x, mirror_y,
    // priority_mask, one zero pad bit.
    logic [sce_pkg::OUT_W-1:0]   m_axis_tdata;
    logic                        m_axis_tlast;

    int   mismatches;
    int   placements_pending;
    int   placements_checked;
    int   entries_sent;
    int   inactive_sent;
    int   settings_written;
    int   idle_cycles;
    // Set for the final stretch of the run, where neither side idles.
    logic quiet_tail;
    // Chosen per group of entries: whether the sender leaves gaps at all.
    logic tx_gappy;

    sprite_chain_expander uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    sce_placement_checker checker_i
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .s_axis_tvalid      (s_axis_tvalid),
        .s_axis_tready      (s_axis_tready),
        .s_axis_tdata       (s_axis_tdata),
        .m_axis_tvalid      (m_axis_tvalid),
        .m_axis_tready      (m_axis_tready),
        .m_axis_tdata       (m_axis_tdata),
        .m_axis_tlast       (m_axis_tlast),
        .mismatches         (mismatches),
        .placements_pending (placements_pending),
        .placements_checked (placements_checked)
    );

    // 12 ns clock period.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Lays the eight bytes of an entry out the way the input word carries them.
    function automatic logic [63:0] pack_entry(input logic [15:0] x, input logic [15:0] y,
                                               input logic [7:0] ctrl, input logic [15:0] code,
                                               input logic [7:0] colour);
        return {colour, code, ctrl, y, x};
    endfunction

    // Coordinates lean toward the edges of the 16-bit range now and then, so
    // that chains cross the sign boundary and run past the positive limit.
    function automatic logic [15:0] random_coord();
        case ($urandom_range(0, 7))
            0: return 16'h7fff - 16'($urandom_range(0, 127));
            1: return 16'h8000 + 16'($urandom_range(0, 127));
            2: return 16'($urandom_range(0, 127)) - 16'd64;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [63:0] random_entry();
        logic [7:0]  ctrl;
        logic [15:0] code;
        ctrl = 8'($urandom_range(0, 255));
        // Most entries are live; a few are skipped by the block.
        if ($urandom_range(0, 99) < 85)
            ctrl = ctrl & ~CTRL_INACTIVE;
        code = 16'($urandom_range(0, 65535));
        // Sometimes place the base at the top so the increment runs past 14 bits.
        if ($urandom_range(0, 7) == 0)
            code = code | 16'h3ff8;
        return pack_entry(random_coord(), random_coord(), ctrl, code,
                          8'($urandom_range(0, 255)));
    endfunction

    // Offers one entry and holds it until the block takes it. Unless a gap is drawn, the
    // valid is left high so that back-to-back entries go without a gap.
    task automatic send_entry(input logic [63:0] entry);
        s_axis_tdata  <= entry;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        entries_sent++;
        if (entry[sce_pkg::CTRL_INACTIVE_BIT])
            inactive_sent++;
        if (!quiet_tail && tx_gappy && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Changes the priority word only once the block has gone quiet.
    task automatic write_priority(input logic [15:0] value);
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (placements_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_written++;
    endtask

    // Receiver: ready most of the time, with bursts of refusal in some
    // stretches and one long hold-off that backs the block up to its input.
    initial
    begin
        int   turns_left;
        logic gappy;
        logic held_once;
        turns_left = 0;
        gappy      = 1'b0;
        held_once  = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (turns_left == 0)
            begin
                gappy      = ($urandom_range(0, 2) != 0);
                turns_left = $urandom_range(20, 80);
            end
            turns_left--;
            if (!held_once && !quiet_tail && placements_checked >= 600)
            begin
                held_once = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet_tail && gappy && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Watchdog: any accepted word or register write counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [15:0] prio_settings [NUM_SETTINGS];
        logic [7:0]  ctrl;
        prio_settings[0] = 16'hffff;
        prio_settings[1] = 16'h0000;
        prio_settings[2] = 16'h0800;
        prio_settings[3] = 16'h77ff;
        prio_settings[4] = 16'h8000;
        prio_settings[5] = 16'($urandom_range(0, 65535));
        entries_sent     = 0;
        inactive_sent    = 0;
        settings_written = 0;
        idle_cycles      = 0;
        quiet_tail       = 1'b0;
        tx_gappy         = 1'b1;
        rst_n            = 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed entries under the priority word as reset leaves it.
        send_entry(pack_entry(16'h0000, 16'h0000, 8'h00, 16'h0000, 8'h00));
        // Inactive entries give nothing, whatever else they hold.
        send_entry(pack_entry(16'hffff, 16'hffff, CTRL_INACTIVE, 16'hffff, 8'hff));
        send_entry(pack_entry(16'h1234, 16'h5678, 8'hff, 16'h3fff, 8'h0f));
        // Longest X chain from the positive limit; the code runs past 0x3fff
        // and the top bits of the code are dropped.
        send_entry(pack_entry(16'h7fff, 16'h0000, 8'h07, 16'hffff, 8'h0f));
        // Flipped X chains start at the far end and step back.
        send_entry(pack_entry(16'h7fff, 16'h8000, CTRL_FLIP_X | 8'h07, 16'h0000, 8'h05));
        send_entry(pack_entry(16'h8000, 16'h7fff, CTRL_FLIP_X | 8'h07, 16'h2aaa, 8'ha0));
        // Y chains, flipped and not, from both ends of the range.
        send_entry(pack_entry(16'h0010, 16'h7fff, CTRL_CHAIN_Y | CTRL_FLIP_Y | 8'h07,
                              16'h1555, 8'h3c));
        send_entry(pack_entry(16'hfff0, 16'h8000, CTRL_CHAIN_Y | 8'h07, 16'h3ffc, 8'hc3));
        // A flip across the chain axis only sets the mirror bit.
        send_entry(pack_entry(16'h0100, 16'h0200, CTRL_FLIP_Y | 8'h07, 16'h0100, 8'h01));
        send_entry(pack_entry(16'h0100, 16'h0200, CTRL_CHAIN_Y | CTRL_FLIP_X | 8'h07,
                              16'h0100, 8'h02));
        // Every flag but the inactive one at once, with the unused control bit set too.
        send_entry(pack_entry(16'hffff, 16'hffff, CTRL_SPARE | CTRL_FLIP_X | CTRL_FLIP_Y |
                              CTRL_CHAIN_Y | 8'h07, 16'hffff, 8'hff));
        send_entry(pack_entry(16'h00ff, 16'hff00, CTRL_SPARE, 16'hc000, 8'hf0));
        // The remaining chain lengths with alternating axis, and both flips on lengths 3 and 6.
        for (int k = 1; k <= 6; k++)
        begin
            ctrl = 8'(k);
            if (k % 2 == 1)
                ctrl = ctrl | CTRL_CHAIN_Y;
            if (k % 3 == 0)
                ctrl = ctrl | CTRL_FLIP_X | CTRL_FLIP_Y;
            send_entry(pack_entry(16'(k * 700), 16'(-k * 700), ctrl, 16'(k * 4093), 8'(k)));
        end

        // Random entries, one block of them under each priority word.
        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            write_priority(prio_settings[s]);
            quiet_tail = (s == NUM_SETTINGS - 1);
            for (int i = 0; i < ENTRIES_PER_SETTING; i++)
            begin
                if (i % 25 == 0)
                    tx_gappy = ($urandom_range(0, 2) != 0);
                send_entry(random_entry());
            end
        end

        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (placements_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d sprite entries (%0d inactive) across %0d priority word settings,",
                 entries_sent, inactive_sent, settings_written);
        $display("checking %0d tile placements with idling, one long hold-off and a calm tail.",
                 placements_checked);
        if (mismatches == 0 && placements_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
